// ===== rtl/lfpid_pkg.sv =====
// Shared types, constants and helper functions for the line-follower PID drive.
// Used by the controller, the datapath and the top level; depends on nothing.
package lfpid_pkg;

	localparam int SENSOR_COUNT = 6;

	localparam logic signed [4:0] SENSOR_WEIGHT [SENSOR_COUNT] =
		'{-5'sd5, -5'sd3, -5'sd1, 5'sd1, 5'sd3, 5'sd5};

	localparam int RECIP_SHIFT = 20;

	typedef enum logic [2:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_INTEG_GAIN  = 3'd1,
		REG_DERIV_GAIN  = 3'd2,
		REG_INTEG_LIMIT = 3'd3,
		REG_CRUISE_DUTY = 3'd4,
		REG_DUTY_LIMIT  = 3'd5
	} cfg_reg_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_RECIP,
		OP_ERROR,
		OP_MUL_P,
		OP_MUL_I,
		OP_MUL_D,
		OP_SUM,
		OP_DRIVE
	} dp_op_t;

	typedef struct packed {
		logic   capture;
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic out_full;
	} dp_status_t;

	// Rounded-up reciprocal of the detecting sensor count, scaled by 2^RECIP_SHIFT.
	function automatic logic [20:0] count_recip(input logic [2:0] count);
		logic [20:0] r;
		case (count)
			3'd1: r = 21'd1048576;
			3'd2: r = 21'd524288;
			3'd3: r = 21'd349526;
			3'd4: r = 21'd262144;
			3'd5: r = 21'd209716;
			3'd6: r = 21'd174763;
			default: r = 21'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/lfpid_ctrl.sv =====
// Sequencer for the line-follower PID drive: steps the datapath through one sample.
// Depends on lfpid_pkg for the command and status types.
module lfpid_ctrl
	import lfpid_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RECIP,
		ST_ERROR,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D,
		ST_SUM,
		ST_DRIVE
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd.capture = in_valid && (state_q == ST_IDLE);
		case (state_q)
			ST_RECIP: cmd.op = OP_RECIP;
			ST_ERROR: cmd.op = OP_ERROR;
			ST_MUL_P: cmd.op = OP_MUL_P;
			ST_MUL_I: cmd.op = OP_MUL_I;
			ST_MUL_D: cmd.op = OP_MUL_D;
			ST_SUM:   cmd.op = OP_SUM;
			ST_DRIVE: cmd.op = status.out_full ? OP_NONE : OP_DRIVE;
			default:  cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_RECIP;
				end
				ST_RECIP: state_q <= ST_ERROR;
				ST_ERROR: state_q <= ST_MUL_P;
				ST_MUL_P: state_q <= ST_MUL_I;
				ST_MUL_I: state_q <= ST_MUL_D;
				ST_MUL_D: state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_DRIVE;
				ST_DRIVE: begin
					if (!status.out_full) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid) |=> (state_q == ST_RECIP))
		else $error("Accepted sample did not start the sequence.");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRIVE && status.out_full) |=> (state_q == ST_DRIVE))
		else $error("Result left the drive step while the output was full.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_DRIVE) |-> !status.out_full)
		else $error("Drive issued over an untaken result.");

endmodule

// ===== rtl/lfpid_datapath.sv =====
// Datapath of the line-follower PID drive: configuration registers, error estimate,
// shared multiplier, PID accumulation, motor saturation and output register.
// Depends on lfpid_pkg.
module lfpid_datapath
	import lfpid_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_status_t  status,
	input  logic [5:0]  sensor_levels,
	input  logic        cfg_valid,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] left_duty,
	output logic        left_reverse,
	output logic [11:0] right_duty,
	output logic        right_reverse,
	output logic        line_lost
);

	logic [15:0] prop_gain_q;
	logic [15:0] integ_gain_q;
	logic [15:0] deriv_gain_q;
	logic [14:0] integ_limit_q;
	logic [11:0] cruise_duty_q;
	logic [11:0] duty_limit_q;

	logic [5:0]          levels_q;
	logic signed [11:0]  prev_err_q;
	logic signed [15:0]  esum_q;
	logic signed [11:0]  err_q;
	logic signed [12:0]  deriv_q;
	logic                lost_q;
	logic signed [38:0]  prod_q;
	logic signed [34:0]  total_q;

	logic                out_valid_q;
	logic [11:0]         left_duty_q;
	logic                left_reverse_q;
	logic [11:0]         right_duty_q;
	logic                right_reverse_q;
	logic                line_lost_q;

	logic [2:0]          seen_count;
	logic signed [4:0]   weight_sum;
	logic [3:0]          weight_mag;
	logic [20:0]         mul_a;
	logic signed [16:0]  mul_b;
	logic signed [38:0]  product;
	logic [11:0]         quot;
	logic signed [11:0]  err_new;
	logic signed [16:0]  acc_sum;
	logic signed [16:0]  lim_pos;
	logic signed [16:0]  lim_neg;
	logic signed [16:0]  acc_clamped;
	logic signed [12:0]  deriv_new;
	logic signed [34:0]  corr_biased;
	logic signed [18:0]  corr;
	logic signed [20:0]  base_ext;
	logic signed [20:0]  corr_ext;
	logic [12:0]         drive_l;
	logic [12:0]         drive_r;

	function automatic logic [12:0] drive_motor(input logic signed [20:0] speed,
		input logic [11:0] limit);
		logic signed [20:0] lim_p;
		logic signed [20:0] sat;
		logic signed [20:0] mag;
		lim_p = $signed({9'b0, limit});
		if (speed > lim_p) sat = lim_p;
		else if (speed < -lim_p) sat = -lim_p;
		else sat = speed;
		mag = -sat;
		if (sat[20]) return {1'b1, mag[11:0]};
		return {1'b0, sat[11:0]};
	endfunction

	always_comb begin
		seen_count = '0;
		weight_sum = '0;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			if (!levels_q[i]) begin
				seen_count = seen_count + 3'd1;
				weight_sum = weight_sum + SENSOR_WEIGHT[i];
			end
		end
	end

	assign weight_mag = weight_sum[4] ? 4'(-weight_sum) : weight_sum[3:0];

	always_comb begin
		case (cmd.op)
			OP_RECIP: begin
				mul_a = count_recip(seen_count);
				mul_b = $signed({5'b0, weight_mag, 8'b0});
			end
			OP_MUL_P: begin
				mul_a = {5'b0, prop_gain_q};
				mul_b = {{5{err_q[11]}}, err_q};
			end
			OP_MUL_I: begin
				mul_a = {5'b0, integ_gain_q};
				mul_b = {esum_q[15], esum_q};
			end
			OP_MUL_D: begin
				mul_a = {5'b0, deriv_gain_q};
				mul_b = {{4{deriv_q[12]}}, deriv_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign product = $signed({1'b0, mul_a}) * mul_b;

	assign quot = prod_q[RECIP_SHIFT+11:RECIP_SHIFT];

	always_comb begin
		if (seen_count == 3'd0) err_new = prev_err_q;
		else if (weight_sum[4]) err_new = $signed(12'd0 - quot);
		else err_new = $signed(quot);
	end

	assign acc_sum   = {esum_q[15], esum_q} + {{5{err_new[11]}}, err_new};
	assign lim_pos   = $signed({2'b00, integ_limit_q});
	assign lim_neg   = -lim_pos;
	assign deriv_new = {err_new[11], err_new} - {prev_err_q[11], prev_err_q};

	always_comb begin
		if (acc_sum > lim_pos) acc_clamped = lim_pos;
		else if (acc_sum < lim_neg) acc_clamped = lim_neg;
		else acc_clamped = acc_sum;
	end

	// Adding 2^16-1 to a negative total makes the arithmetic shift round toward zero.
	assign corr_biased = total_q + (total_q[34] ? 35'sd65535 : 35'sd0);
	assign corr        = corr_biased[34:16];
	assign base_ext    = $signed({9'b0, cruise_duty_q});
	assign corr_ext    = {{2{corr[18]}}, corr};
	assign drive_l     = drive_motor(base_ext + corr_ext, duty_limit_q);
	assign drive_r     = drive_motor(base_ext - corr_ext, duty_limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= 16'd20480;
			integ_gain_q  <= 16'd26;
			deriv_gain_q  <= 16'd51200;
			integ_limit_q <= 15'd25600;
			cruise_duty_q <= 12'd400;
			duty_limit_q  <= 12'd999;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_PROP_GAIN:   prop_gain_q   <= cfg_data;
				REG_INTEG_GAIN:  integ_gain_q  <= cfg_data;
				REG_DERIV_GAIN:  deriv_gain_q  <= cfg_data;
				REG_INTEG_LIMIT: integ_limit_q <= cfg_data[14:0];
				REG_CRUISE_DUTY: cruise_duty_q <= cfg_data[11:0];
				REG_DUTY_LIMIT:  duty_limit_q  <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			esum_q     <= '0;
		end else if (cmd.op == OP_ERROR) begin
			prev_err_q <= err_new;
			esum_q     <= acc_clamped[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) levels_q <= sensor_levels;
		case (cmd.op)
			OP_RECIP: prod_q <= product;
			OP_ERROR: begin
				err_q   <= err_new;
				deriv_q <= deriv_new;
				lost_q  <= (seen_count == 3'd0);
			end
			OP_MUL_P: prod_q <= product;
			OP_MUL_I: begin
				total_q <= prod_q[34:0];
				prod_q  <= product;
			end
			OP_MUL_D: begin
				total_q <= total_q + $signed(prod_q[34:0]);
				prod_q  <= product;
			end
			OP_SUM: total_q <= total_q + $signed(prod_q[34:0]);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_DRIVE) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_DRIVE) begin
			left_reverse_q  <= drive_l[12];
			left_duty_q     <= drive_l[11:0];
			right_reverse_q <= drive_r[12];
			right_duty_q    <= drive_r[11:0];
			line_lost_q     <= lost_q;
		end
	end

	assign status.out_full = out_valid_q && !out_ready;
	assign out_valid       = out_valid_q;
	assign left_duty       = left_duty_q;
	assign left_reverse    = left_reverse_q;
	assign right_duty      = right_duty_q;
	assign right_reverse   = right_reverse_q;
	assign line_lost       = line_lost_q;

	a_integ_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_ERROR) |=>
		(esum_q <= $signed({1'b0, $past(integ_limit_q)})) &&
		(esum_q >= -$signed({1'b0, $past(integ_limit_q)})))
		else $error("Integral left its clamp range.");

	a_duty_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_DRIVE) |=>
		(left_duty_q <= $past(duty_limit_q)) && (right_duty_q <= $past(duty_limit_q)))
		else $error("Duty exceeds the saturation bound.");

	a_reverse_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (left_reverse_q || right_reverse_q)) |->
		((!left_reverse_q || left_duty_q != 12'd0) &&
		 (!right_reverse_q || right_duty_q != 12'd0)))
		else $error("Reverse flag set with zero duty.");

endmodule

// ===== rtl/line_follow_pid_motor_drive.sv =====
// Top level of the line-follower PID motor drive.
// Joins lfpid_ctrl and lfpid_datapath; depends on lfpid_pkg.
//
// Usage: one sample of six active-low sensor levels is a transfer on the
// in_valid/in_ready channel. Each sample gives exactly one result transfer on
// out_valid/out_ready carrying both motor duties, their reverse bits and the
// line_lost flag. Gains, integral limit, cruise duty and duty limit are written
// through cfg_valid/cfg_index/cfg_data; cfg_ready is always high, and an
// unused index is ignored. Write configuration only while no sample is in work.
//
// A sample passes these steps from its transfer until its result is in the output
// register: the reciprocal multiply that divides by the sensor count, the error
// and integral update, the P, I and D products on the shared multiplier, the
// final sum and saturation.
// The next sample is taken only once the previous result is in that register.
// The result waits in the output register while the receiver stalls; a further
// sample is still taken and worked on, and it waits at the drive step until
// the earlier result has been taken.
// Reset clears the previous error and the integral and loads the default
// configuration; the block is ready in the first cycle after reset.
module line_follow_pid_motor_drive
	import lfpid_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [5:0]  sensor_levels,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] left_duty,
	output logic        left_reverse,
	output logic [11:0] right_duty,
	output logic        right_reverse,
	output logic        line_lost,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	lfpid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	lfpid_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.sensor_levels (sensor_levels),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.left_duty     (left_duty),
		.left_reverse  (left_reverse),
		.right_duty    (right_duty),
		.right_reverse (right_reverse),
		.line_lost     (line_lost)
	);

endmodule
